@@ src/cme_pkg.sv @@
// Shared types, codes and constants for the clock master election engine.
// Used by cme_ctrl, cme_dp and clock_master_election_fsm_unit; no dependencies.
package cme_pkg;

   localparam int ADDR_W = 32;
   localparam int RAND_W = 16;
   localparam int CFG_W  = 16;
   localparam int CNT_W  = 17;
   localparam int ROLE_W = 3;
   localparam int CMD_W  = 4;
   localparam int ACT_W  = 2;
   localparam int SEC_W  = 32;
   localparam int USEC_W = 20;
   localparam int CSR_IDX_W = 3;
   localparam int DIV_CNT_W = $clog2(RAND_W);

   typedef logic [ROLE_W-1:0] role_type;
   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [ACT_W-1:0]  act_type;
   typedef logic [1:0]        dsel_type;

   // roles
   localparam role_type ROLE_STARTUP   = 3'd0;
   localparam role_type ROLE_SLAVE     = 3'd1;
   localparam role_type ROLE_CANDIDATE = 3'd2;
   localparam role_type ROLE_ACCEPT    = 3'd3;
   localparam role_type ROLE_MASTER    = 3'd4;
   localparam role_type ROLE_ADJUST    = 3'd5;

   // protocol commands
   localparam cmd_type MSG_MASTER_REQ  = 4'd0;
   localparam cmd_type MSG_MASTER_UP   = 4'd1;
   localparam cmd_type MSG_SLAVE_UP    = 4'd2;
   localparam cmd_type MSG_MASTER_ACK  = 4'd3;
   localparam cmd_type MSG_ELECTION    = 4'd4;
   localparam cmd_type MSG_ACCEPT      = 4'd5;
   localparam cmd_type MSG_REFUSE      = 4'd6;
   localparam cmd_type MSG_QUIT        = 4'd7;
   localparam cmd_type MSG_ACK         = 4'd8;
   localparam cmd_type MSG_CLOCK_REQ   = 4'd9;
   localparam cmd_type MSG_CLOCK_REPLY = 4'd10;
   localparam cmd_type MSG_TIME_SYNC   = 4'd11;

   // local actions
   localparam act_type ACT_PREPARE   = 2'd0;
   localparam act_type ACT_ADDSAMPLE = 2'd1;
   localparam act_type ACT_COMPUTE   = 2'd2;
   localparam act_type ACT_ADJUST    = 2'd3;

   // destination select
   localparam dsel_type DSEL_ZERO  = 2'd0;
   localparam dsel_type DSEL_SRC   = 2'd1;
   localparam dsel_type DSEL_BCAST = 2'd2;

   localparam logic MODE_TICK = 1'b0;
   localparam logic KIND_PKT  = 1'b0;
   localparam logic KIND_ACT  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER_PERIOD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADJUST_WINDOW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CANDIDATE_WINDOW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_WINDOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RANDOM_MIN       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RANDOM_SPAN      = 3'd5;

   localparam logic [CFG_W-1:0] MASTER_PERIOD_RST    = 16'd60;
   localparam logic [CFG_W-1:0] ADJUST_WINDOW_RST    = 16'd30;
   localparam logic [CFG_W-1:0] CANDIDATE_WINDOW_RST = 16'd30;
   localparam logic [CFG_W-1:0] ACCEPT_WINDOW_RST    = 16'd30;
   localparam logic [CFG_W-1:0] RANDOM_MIN_RST       = 16'd66;
   localparam logic [CFG_W-1:0] RANDOM_SPAN_RST      = 16'd120;

   localparam logic [RAND_W-1:0] RAND_SEED = 16'hACE1;

   // one LFSR step, taps 0,2,3,5; a zero state is reseeded first
   function automatic logic [RAND_W-1:0] lfsr_next(input logic [RAND_W-1:0] r);
      logic [RAND_W-1:0] v;
      logic              b;
      v = r;
      if (v == '0) begin
         v = RAND_SEED;
      end
      b = v[0] ^ v[2] ^ v[3] ^ v[5];
      return {b, v[RAND_W-1:1]};
   endfunction

   // state after reset: first draw already taken with the reset register values
   localparam logic [RAND_W-1:0] RAND_FIRST = lfsr_next(RAND_SEED);
   localparam logic [CNT_W-1:0]  COUNT_RST  =
      CNT_W'(RANDOM_MIN_RST) + CNT_W'(RAND_FIRST % RANDOM_SPAN_RST);

   typedef struct packed {
      logic              mode;
      cmd_type           msg_cmd;
      logic [ADDR_W-1:0] src_addr;
      logic [SEC_W-1:0]  msg_sec;
      logic [USEC_W-1:0] msg_usec;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] dest_addr;
      cmd_type           send_cmd;
      logic              with_time;
      act_type           action;
      logic [SEC_W-1:0]  act_sec;
      logic [USEC_W-1:0] act_usec;
      role_type          role;
      logic              last;
   } rsp_type;

   // what one result item carries, before the message payload is filled in
   typedef struct packed {
      logic     is_act;
      dsel_type dsel;
      cmd_type  cmd;
      logic     with_time;
      act_type  act;
      logic     tsel;
   } desc_type;

   typedef struct packed {
      logic     capture;
      logic     dec_count;
      logic     load_window;
      role_type win_role;
      logic     start_draw;
      logic     load_out;
      desc_type desc;
      role_type out_role;
      logic     out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic timeout;
      logic draw_done;
   } dp_stat_type;

endpackage

@@ src/cme_ctrl.sv @@
// Election controller: role register, event decode and handshake sequencing.
// Depends on cme_pkg; drives cme_dp through dp_cmd_type and reads dp_stat_type.
module cme_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  cme_pkg::cmd_type     req_cmd,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cme_pkg::dp_cmd_type  dp_cmd,
   input  cme_pkg::dp_stat_type dp_stat
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAW,
      ST_SEND
   } state_type;

   state_type          state_ff;
   cme_pkg::role_type  role_ff;
   cme_pkg::desc_type  desc1_ff;
   logic               pend2_ff;
   logic               has_res_ff;

   logic               accept;
   logic               is_event;
   logic               tmo;
   logic [1:0]         nres;
   cme_pkg::desc_type  d0;
   cme_pkg::desc_type  d1;
   cme_pkg::role_type  nrole;
   logic               reenter;
   logic               random_role;

   function automatic cme_pkg::desc_type pkt(input cme_pkg::dsel_type dsel,
                                              input cme_pkg::cmd_type  cmd,
                                              input logic              wt);
      cme_pkg::desc_type d;
      d           = '0;
      d.is_act    = cme_pkg::KIND_PKT;
      d.dsel      = dsel;
      d.cmd       = cmd;
      d.with_time = wt;
      return d;
   endfunction

   function automatic cme_pkg::desc_type act(input cme_pkg::act_type  a,
                                              input cme_pkg::dsel_type dsel,
                                              input logic              tsel);
      cme_pkg::desc_type d;
      d        = '0;
      d.is_act = cme_pkg::KIND_ACT;
      d.dsel   = dsel;
      d.act    = a;
      d.tsel   = tsel;
      return d;
   endfunction

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign tmo      = (req_mode == cme_pkg::MODE_TICK) && dp_stat.timeout;
   assign is_event = (req_mode != cme_pkg::MODE_TICK) || dp_stat.timeout;

   // protocol decode; a timeout takes precedence over the command field
   always_comb begin
      nres    = 2'd0;
      d0      = '0;
      d1      = '0;
      nrole   = role_ff;
      reenter = 1'b0;
      case (role_ff)
         cme_pkg::ROLE_STARTUP: begin
            if (tmo) begin
               nres = 2'd1; d0 = pkt(cme_pkg::DSEL_BCAST, cme_pkg::MSG_MASTER_UP, 1'b0);
               nrole = cme_pkg::ROLE_MASTER; reenter = 1'b1;
            end else if (req_cmd == cme_pkg::MSG_MASTER_UP) begin
               nres = 2'd1; d0 = pkt(cme_pkg::DSEL_SRC, cme_pkg::MSG_SLAVE_UP, 1'b0);
               nrole = cme_pkg::ROLE_SLAVE; reenter = 1'b1;
            end else if (req_cmd == cme_pkg::MSG_MASTER_REQ ||
                         req_cmd == cme_pkg::MSG_MASTER_ACK ||
                         req_cmd == cme_pkg::MSG_ELECTION) begin
               nrole = cme_pkg::ROLE_SLAVE; reenter = 1'b1;
            end
         end
         cme_pkg::ROLE_MASTER: begin
            if (tmo) begin
               nres = 2'd2;
               d0 = pkt(cme_pkg::DSEL_BCAST, cme_pkg::MSG_CLOCK_REQ, 1'b1);
               d1 = act(cme_pkg::ACT_PREPARE, cme_pkg::DSEL_ZERO, 1'b0);
               nrole = cme_pkg::ROLE_ADJUST; reenter = 1'b1;
            end else if (req_cmd == cme_pkg::MSG_MASTER_REQ) begin
               nres = 2'd1; d0 = pkt(cme_pkg::DSEL_SRC, cme_pkg::MSG_MASTER_ACK, 1'b0);
            end else if (req_cmd == cme_pkg::MSG_QUIT) begin
               nres = 2'd1; d0 = pkt(cme_pkg::DSEL_SRC, cme_pkg::MSG_ACK, 1'b0);
               nrole = cme_pkg::ROLE_SLAVE; reenter = 1'b1;
            end else if (req_cmd == cme_pkg::MSG_ELECTION ||
                         req_cmd == cme_pkg::MSG_MASTER_UP) begin
               nres = 2'd1; d0 = pkt(cme_pkg::DSEL_SRC, cme_pkg::MSG_QUIT, 1'b0);
            end
         end
         cme_pkg::ROLE_ADJUST: begin
            if (tmo) begin
               nres = 2'd1; d0 = act(cme_pkg::ACT_COMPUTE, cme_pkg::DSEL_ZERO, 1'b0);
               nrole = cme_pkg::ROLE_MASTER; reenter = 1'b1;
            end else if (req_cmd == cme_pkg::MSG_CLOCK_REPLY) begin
               nres = 2'd1; d0 = act(cme_pkg::ACT_ADDSAMPLE, cme_pkg::DSEL_SRC, 1'b1);
            end
         end
         cme_pkg::ROLE_SLAVE: begin
            if (tmo) begin
               nres = 2'd1; d0 = pkt(cme_pkg::DSEL_BCAST, cme_pkg::MSG_ELECTION, 1'b0);
               nrole = cme_pkg::ROLE_CANDIDATE; reenter = 1'b1;
            end else if (req_cmd == cme_pkg::MSG_CLOCK_REQ) begin
               nres = 2'd1; d0 = pkt(cme_pkg::DSEL_SRC, cme_pkg::MSG_CLOCK_REPLY, 1'b1);
               reenter = 1'b1;
            end else if (req_cmd == cme_pkg::MSG_MASTER_UP) begin
               nres = 2'd1; d0 = pkt(cme_pkg::DSEL_BCAST, cme_pkg::MSG_SLAVE_UP, 1'b0);
            end else if (req_cmd == cme_pkg::MSG_ELECTION) begin
               nres = 2'd1; d0 = pkt(cme_pkg::DSEL_SRC, cme_pkg::MSG_ACCEPT, 1'b0);
               nrole = cme_pkg::ROLE_ACCEPT; reenter = 1'b1;
            end else if (req_cmd == cme_pkg::MSG_TIME_SYNC) begin
               nres = 2'd1; d0 = act(cme_pkg::ACT_ADJUST, cme_pkg::DSEL_ZERO, 1'b1);
               reenter = 1'b1;
            end
         end
         cme_pkg::ROLE_CANDIDATE: begin
            if (tmo) begin
               nres = 2'd1; d0 = pkt(cme_pkg::DSEL_BCAST, cme_pkg::MSG_MASTER_UP, 1'b0);
               nrole = cme_pkg::ROLE_MASTER; reenter = 1'b1;
            end else if (req_cmd == cme_pkg::MSG_ELECTION) begin
               nres = 2'd1; d0 = pkt(cme_pkg::DSEL_SRC, cme_pkg::MSG_REFUSE, 1'b0);
            end else if (req_cmd == cme_pkg::MSG_ACCEPT) begin
               nres = 2'd1; d0 = pkt(cme_pkg::DSEL_SRC, cme_pkg::MSG_ACK, 1'b0);
            end else if (req_cmd == cme_pkg::MSG_QUIT ||
                         req_cmd == cme_pkg::MSG_REFUSE) begin
               nres = 2'd1; d0 = pkt(cme_pkg::DSEL_SRC, cme_pkg::MSG_ACK, 1'b0);
               nrole = cme_pkg::ROLE_SLAVE; reenter = 1'b1;
            end else if (req_cmd == cme_pkg::MSG_MASTER_REQ) begin
               nrole = cme_pkg::ROLE_SLAVE; reenter = 1'b1;
            end
         end
         cme_pkg::ROLE_ACCEPT: begin
            if (tmo) begin
               nrole = cme_pkg::ROLE_SLAVE; reenter = 1'b1;
            end else if (req_cmd == cme_pkg::MSG_ELECTION) begin
               nres = 2'd1; d0 = pkt(cme_pkg::DSEL_SRC, cme_pkg::MSG_REFUSE, 1'b0);
            end else if (req_cmd == cme_pkg::MSG_MASTER_UP) begin
               nres = 2'd1; d0 = pkt(cme_pkg::DSEL_SRC, cme_pkg::MSG_SLAVE_UP, 1'b0);
            end
         end
         default: begin
            nres = 2'd0;
         end
      endcase
   end

   assign random_role = (nrole == cme_pkg::ROLE_STARTUP) || (nrole == cme_pkg::ROLE_SLAVE);

   always_comb begin
      dp_cmd = '0;
      if (accept) begin
         if (!is_event) begin
            dp_cmd.dec_count = 1'b1;
         end else begin
            dp_cmd.capture     = 1'b1;
            dp_cmd.load_out    = (nres != 2'd0);
            dp_cmd.desc        = d0;
            dp_cmd.out_role    = nrole;
            dp_cmd.out_last    = (nres == 2'd1);
            dp_cmd.start_draw  = reenter && random_role;
            dp_cmd.load_window = reenter && !random_role;
            dp_cmd.win_role    = nrole;
         end
      end else if ((state_ff == ST_SEND) && !rsp_stall && pend2_ff) begin
         dp_cmd.load_out = 1'b1;
         dp_cmd.desc     = desc1_ff;
         dp_cmd.out_role = role_ff;
         dp_cmd.out_last = 1'b1;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_SEND);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         role_ff    <= cme_pkg::ROLE_STARTUP;
         pend2_ff   <= 1'b0;
         has_res_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && is_event) begin
                  role_ff    <= nrole;
                  desc1_ff   <= d1;
                  pend2_ff   <= (nres == 2'd2);
                  has_res_ff <= (nres != 2'd0);
                  if (reenter && random_role) begin
                     state_ff <= ST_DRAW;
                  end else if (nres != 2'd0) begin
                     state_ff <= ST_SEND;
                  end
               end
            end
            ST_DRAW: begin
               if (dp_stat.draw_done) begin
                  state_ff <= has_res_ff ? ST_SEND : ST_IDLE;
               end
            end
            ST_SEND: begin
               if (!rsp_stall) begin
                  if (pend2_ff) begin
                     pend2_ff <= 1'b0;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ src/cme_dp.sv @@
// Election datapath: registers, countdown, LFSR with bit-serial modulo, result register.
// Depends on cme_pkg; commanded by cme_ctrl.
module cme_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [cme_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cme_pkg::CFG_W-1:0]            csr_data,
   input  cme_pkg::req_type                     req_data,
   input  cme_pkg::dp_cmd_type                  dp_cmd,
   output cme_pkg::dp_stat_type                 dp_stat,
   output cme_pkg::rsp_type                     rsp_data
);

   localparam logic [cme_pkg::DIV_CNT_W-1:0] DIV_LAST = cme_pkg::DIV_CNT_W'(cme_pkg::RAND_W - 1);

   logic [cme_pkg::CFG_W-1:0]      master_period_ff;
   logic [cme_pkg::CFG_W-1:0]      adjust_window_ff;
   logic [cme_pkg::CFG_W-1:0]      candidate_window_ff;
   logic [cme_pkg::CFG_W-1:0]      accept_window_ff;
   logic [cme_pkg::CFG_W-1:0]      random_min_ff;
   logic [cme_pkg::CFG_W-1:0]      random_span_ff;

   logic [cme_pkg::CNT_W-1:0]      count_ff;
   logic [cme_pkg::CNT_W-1:0]      count_in;
   logic [cme_pkg::RAND_W-1:0]     lfsr_ff;
   logic [cme_pkg::RAND_W-1:0]     lfsr_in;

   logic                           div_busy_ff;
   logic [cme_pkg::DIV_CNT_W-1:0]  div_cnt_ff;
   logic [cme_pkg::RAND_W-1:0]     div_num_ff;
   logic [cme_pkg::RAND_W-1:0]     rem_ff;
   logic [cme_pkg::RAND_W-1:0]     rem_in;
   logic [cme_pkg::RAND_W:0]       trial;
   logic                           draw_done;

   logic [cme_pkg::ADDR_W-1:0]     src_ff;
   logic [cme_pkg::SEC_W-1:0]      sec_ff;
   logic [cme_pkg::USEC_W-1:0]     usec_ff;

   cme_pkg::desc_type              out_desc_ff;
   cme_pkg::role_type              out_role_ff;
   logic                           out_last_ff;

   logic [cme_pkg::CFG_W-1:0]      window;

   // restoring remainder, one dividend bit per cycle
   assign trial = {rem_ff, div_num_ff[cme_pkg::RAND_W-1]};
   always_comb begin
      if (trial >= {1'b0, random_span_ff}) begin
         rem_in = cme_pkg::RAND_W'(trial - {1'b0, random_span_ff});
      end else begin
         rem_in = trial[cme_pkg::RAND_W-1:0];
      end
   end
   assign draw_done = div_busy_ff && (div_cnt_ff == DIV_LAST);

   assign lfsr_in = cme_pkg::lfsr_next(lfsr_ff);

   always_comb begin
      case (dp_cmd.win_role)
         cme_pkg::ROLE_CANDIDATE: window = candidate_window_ff;
         cme_pkg::ROLE_ACCEPT:    window = accept_window_ff;
         cme_pkg::ROLE_MASTER:    window = master_period_ff;
         default:                 window = adjust_window_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (draw_done) begin
         if (random_span_ff == '0) begin
            count_in = cme_pkg::CNT_W'(random_min_ff);
         end else begin
            count_in = cme_pkg::CNT_W'(random_min_ff) + cme_pkg::CNT_W'(rem_in);
         end
      end else if (dp_cmd.load_window) begin
         count_in = cme_pkg::CNT_W'(window);
      end else if (dp_cmd.dec_count) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign dp_stat.timeout   = (count_ff <= cme_pkg::CNT_W'(1));
   assign dp_stat.draw_done = draw_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         master_period_ff    <= cme_pkg::MASTER_PERIOD_RST;
         adjust_window_ff    <= cme_pkg::ADJUST_WINDOW_RST;
         candidate_window_ff <= cme_pkg::CANDIDATE_WINDOW_RST;
         accept_window_ff    <= cme_pkg::ACCEPT_WINDOW_RST;
         random_min_ff       <= cme_pkg::RANDOM_MIN_RST;
         random_span_ff      <= cme_pkg::RANDOM_SPAN_RST;
         count_ff            <= cme_pkg::COUNT_RST;
         lfsr_ff             <= cme_pkg::RAND_FIRST;
         div_busy_ff         <= 1'b0;
         div_cnt_ff          <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               cme_pkg::CSR_MASTER_PERIOD:    master_period_ff    <= csr_data;
               cme_pkg::CSR_ADJUST_WINDOW:    adjust_window_ff    <= csr_data;
               cme_pkg::CSR_CANDIDATE_WINDOW: candidate_window_ff <= csr_data;
               cme_pkg::CSR_ACCEPT_WINDOW:    accept_window_ff    <= csr_data;
               cme_pkg::CSR_RANDOM_MIN:       random_min_ff       <= csr_data;
               cme_pkg::CSR_RANDOM_SPAN:      random_span_ff      <= csr_data;
               default: ;
            endcase
         end
         count_ff <= count_in;
         if (dp_cmd.start_draw) begin
            lfsr_ff     <= lfsr_in;
            div_busy_ff <= 1'b1;
            div_cnt_ff  <= '0;
         end else if (div_busy_ff) begin
            div_cnt_ff <= div_cnt_ff + 1'b1;
            if (draw_done) begin
               div_busy_ff <= 1'b0;
            end
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (dp_cmd.start_draw) begin
         div_num_ff <= lfsr_in;
         rem_ff     <= '0;
      end else if (div_busy_ff) begin
         div_num_ff <= {div_num_ff[cme_pkg::RAND_W-2:0], 1'b0};
         rem_ff     <= rem_in;
      end
      if (dp_cmd.capture) begin
         src_ff  <= req_data.src_addr;
         sec_ff  <= req_data.msg_sec;
         usec_ff <= req_data.msg_usec;
      end
      if (dp_cmd.load_out) begin
         out_desc_ff <= dp_cmd.desc;
         out_role_ff <= dp_cmd.out_role;
         out_last_ff <= dp_cmd.out_last;
      end
   end

   // result fields follow from registers only, so they hold during a stall
   always_comb begin
      rsp_data           = '0;
      rsp_data.kind      = out_desc_ff.is_act;
      case (out_desc_ff.dsel)
         cme_pkg::DSEL_SRC:   rsp_data.dest_addr = src_ff;
         cme_pkg::DSEL_BCAST: rsp_data.dest_addr = '1;
         default:             rsp_data.dest_addr = '0;
      endcase
      rsp_data.send_cmd  = out_desc_ff.cmd;
      rsp_data.with_time = out_desc_ff.with_time;
      rsp_data.action    = out_desc_ff.act;
      rsp_data.act_sec   = out_desc_ff.tsel ? sec_ff : '0;
      rsp_data.act_usec  = out_desc_ff.tsel ? usec_ff : '0;
      rsp_data.role      = out_role_ff;
      rsp_data.last      = out_last_ff;
   end

endmodule

@@ src/clock_master_election_fsm_unit.sv @@
// Clock master election engine: usage notes
// req channel: one item per timer tick (mode 0) or received message (mode 1).
// rsp channel: zero, one or two result items per accepted item; the final one
//   carries last. Items that cause no result (a tick that only counts down,
//   an unhandled command) produce nothing on rsp.
// csr port: write-only register file, taken at any edge with csr_write_en high;
//   write only while the block is idle.
// Results: the first result is valid the cycle after the transfer. When the
//   item enters the startup or slave role, a bit-serial modulo draws the new
//   random timeout first, and the first result follows once the draw ends.
// Throughput: one item at a time; req_stall is high from the transfer until
//   the last result has transferred (or the draw ends when there is none).
//   A tick with no event never raises req_stall.
// rsp_stall holds the current result in place; req stays stalled meanwhile.
// Reset: synchronous, active high; role startup, registers at defaults, and
//   the first random timeout preloaded, so items are taken right after reset.
// Depends on cme_pkg, cme_ctrl and cme_dp.
module clock_master_election_fsm_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cme_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cme_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_en,
   input  logic [cme_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cme_pkg::CFG_W-1:0]      csr_data
);

   cme_pkg::dp_cmd_type  dp_cmd;
   cme_pkg::dp_stat_type dp_stat;

   cme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_data.mode),
      .req_cmd   (req_data.msg_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   cme_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_data     (req_data),
      .dp_cmd       (dp_cmd),
      .dp_stat      (dp_stat),
      .rsp_data     (rsp_data)
   );

endmodule
